[design/first_fit_block_allocator_macros.svh]
// Assertion macros for the allocator top-level RTL file.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define FFA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define FFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

[design/ffa_pkg.sv]
// Shared types and constants of the first-fit block allocator.
`default_nettype none

package ffa_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Request kinds carried on tuser
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Register file layout
	localparam int  APB_ADDR_W = 3;
	localparam logic REG_REGION_BASE = 1'b0;
	localparam logic REG_POOL_BYTES  = 1'b1;
	localparam logic [15:0] REGION_BASE_RST = 16'd0;
	localparam logic [15:0] POOL_BYTES_RST  = 16'd4096;

	// Saturation limit of the used-byte counter
	localparam logic [16:0] USED_MAX = 17'h1FFFF;

	// Configuration handed from the register file to the core
	typedef struct packed {
		logic [15:0] region_base;
		logic [15:0] pool_bytes;
	} cfg_t;

endpackage

`default_nettype wire

[design/ffa_ram.sv]
// Record table memory: one write port, one registered read port.
`default_nettype none

module ffa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 33
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/ffa_cfg.sv]
// APB register file holding the pool base address and pool size.
`default_nettype none

module ffa_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ffa_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready,
	output ffa_pkg::cfg_t                       cfg
);

	ffa_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic          reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	// register index is the word address; byte offset bits are ignored
	assign reg_sel = paddr[2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_base <= ffa_pkg::REGION_BASE_RST;
			cfg_q.pool_bytes  <= ffa_pkg::POOL_BYTES_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				ffa_pkg::REG_REGION_BASE: cfg_q.region_base <= pwdata[15:0];
				ffa_pkg::REG_POOL_BYTES:  cfg_q.pool_bytes  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_sel)
			ffa_pkg::REG_REGION_BASE: prdata = {16'd0, cfg_q.region_base};
			ffa_pkg::REG_POOL_BYTES:  prdata = {16'd0, cfg_q.pool_bytes};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/first_fit_block_allocator.sv]
// First-fit block allocator: top level with request sequencer and record scan.
//
// Requests enter on the s_ stream (tuser: 0 allocate, 1 free; tdata: size and
// block address), one result word leaves on the m_ stream for each request.
// region_base and pool_bytes sit behind the APB port; the user must write them
// only while idle, the block does not enforce it. An allocate that exceeds the
// unused pool bytes is refused right away. Any other request walks the record
// table in the RAM one record per cycle through its single read port, rewriting
// a record in the cycle after its read is issued. An allocate stops at the first
// free record that fits, else appends a record while fewer than ENTRIES are
// held. A free walks all records. The next request is taken in the cycle after
// the result is loaded into the output register.
// Reset empties the table (no clearing pass: only records below the fill count
// are ever read) and loads the register defaults. A stalled m_ side holds the
// result in the output register; one more request may finish its scan, then
// the block waits until the output word is taken.
`default_nettype none

module first_fit_block_allocator #(
	parameter int ENTRIES   = 64,
	parameter int ADDR_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [31:0]                    s_tdata,  // [15:0] request_size, [31:16] block_address
	input  wire logic                           s_tuser,  // [0] mode
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [23:0]                    m_tdata,  // [15:0] granted_address, [17:16] status
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ffa_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready
);

	`include "first_fit_block_allocator_macros.svh"

	localparam int IW   = $clog2(ENTRIES);
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int AW   = ADDR_BITS;
	localparam int WW   = 1 + 16 + AW;
	localparam int CMPW = (AW > 16) ? AW : 16;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	ffa_pkg::cfg_t    cfg;
	state_t           state_q;

	// request registers
	logic             mode_q;
	logic [15:0]      size_q;
	logic [15:0]      baddr_q;

	// table bookkeeping
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    tail_q;
	logic [16:0]      used_q;
	logic [16:0]      used_next;

	// scan pointer and read stage
	logic [CW-1:0]    rd_idx_q;
	logic             v_s1;
	logic [IW-1:0]    idx_s1;
	logic             hit_q;

	// result staging and output register
	logic [15:0]      res_addr_q;
	ffa_pkg::status_t res_status_q;
	logic             out_valid_q;
	logic [23:0]      out_data_q;

	// memory ports
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [WW-1:0]    mem_wdata;
	logic             mem_re;
	logic [WW-1:0]    mem_rdata;

	// decoded read word and scan decisions
	logic             rd_busy;
	logic [15:0]      rd_len;
	logic [AW-1:0]    rd_start;
	logic [CMPW-1:0]  rd_start_ext;
	logic [CMPW-1:0]  region_ext;
	logic [CMPW-1:0]  append_ext;
	logic [16:0]      unused;
	logic             no_space;
	logic             in_accept;
	logic             issue;
	logic             fit;
	logic             match;
	logic             scan_end;
	logic             append_ok;
	logic [AW-1:0]    append_start;
	logic [17:0]      add_sum;
	logic [15:0]      add_n;
	logic             out_free;

	ffa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ffa_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (WW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	// handshakes
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid & s_tready;
	assign out_free  = ~out_valid_q | m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// free pool bytes, zero when over-committed
	assign unused   = (used_q >= {1'b0, cfg.pool_bytes}) ? 17'd0
		: ({1'b0, cfg.pool_bytes} - used_q);
	assign no_space = ({1'b0, s_tdata[15:0]} > unused);

	// record word layout: {busy, length, start}
	assign rd_busy      = mem_rdata[WW-1];
	assign rd_len       = mem_rdata[AW+15:AW];
	assign rd_start     = mem_rdata[AW-1:0];
	assign rd_start_ext = CMPW'(rd_start);
	assign region_ext   = CMPW'(cfg.region_base);

	// scan decisions
	assign issue    = (state_q == ST_SCAN) && (rd_idx_q != count_q);
	assign mem_re   = issue;
	assign fit      = v_s1 && (mode_q == ffa_pkg::MODE_ALLOC) && !rd_busy && (rd_len >= size_q);
	assign match    = v_s1 && (mode_q == ffa_pkg::MODE_FREE) && rd_busy
		&& (rd_start_ext == CMPW'(baddr_q));
	assign scan_end = (state_q == ST_SCAN) && !v_s1 && !issue;
	assign append_ok = scan_end && (mode_q == ffa_pkg::MODE_ALLOC)
		&& (count_q != CW'(ENTRIES));
	assign append_start = (count_q == '0) ? region_ext[AW-1:0] : tail_q;
	assign append_ext   = CMPW'(append_start);

	// read-modify-write port: mark the scanned record, or append a new one
	assign mem_we    = fit | match | append_ok;
	assign mem_waddr = append_ok ? count_q[IW-1:0] : idx_s1;
	assign mem_wdata = append_ok ? {1'b1, size_q, append_start} : {fit, rd_len, rd_start};

	// used-byte counter, saturating both ways
	assign add_n   = fit ? rd_len : size_q;
	assign add_sum = {1'b0, used_q} + 18'(add_n);
	always_comb begin
		used_next = used_q;
		if (fit || append_ok) begin
			used_next = add_sum[17] ? ffa_pkg::USED_MAX : add_sum[16:0];
		end else if (match) begin
			used_next = ({1'b0, rd_len} >= used_q) ? 17'd0 : (used_q - {1'b0, rd_len});
		end
	end

	// sequencer and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			used_q   <= '0;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			used_q <= used_next;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						rd_idx_q <= '0;
						v_s1     <= 1'b0;
						hit_q    <= 1'b0;
						if ((s_tuser == ffa_pkg::MODE_ALLOC) && no_space) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (fit) begin
						v_s1    <= 1'b0;
						state_q <= ST_RESULT;
					end else if (scan_end) begin
						if (append_ok) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= ST_RESULT;
					end else begin
						v_s1  <= issue;
						hit_q <= hit_q | match;
						if (issue) begin
							rd_idx_q <= rd_idx_q + CW'(1);
						end
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request, read stage and result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q  <= s_tuser;
			size_q  <= s_tdata[15:0];
			baddr_q <= s_tdata[31:16];
			if ((s_tuser == ffa_pkg::MODE_ALLOC) && no_space) begin
				res_addr_q   <= 16'd0;
				res_status_q <= ffa_pkg::ST_NOSPACE;
			end
		end
		if (issue) begin
			idx_s1 <= rd_idx_q[IW-1:0];
		end
		if (fit) begin
			res_addr_q   <= rd_start_ext[15:0];
			res_status_q <= ffa_pkg::ST_OK;
		end else if (scan_end) begin
			if (mode_q == ffa_pkg::MODE_FREE) begin
				res_addr_q   <= 16'd0;
				res_status_q <= (hit_q | match) ? ffa_pkg::ST_OK : ffa_pkg::ST_NOTFOUND;
			end else if (append_ok) begin
				res_addr_q   <= append_ext[15:0];
				res_status_q <= ffa_pkg::ST_OK;
			end else begin
				res_addr_q   <= 16'd0;
				res_status_q <= ffa_pkg::ST_FULL;
			end
		end
		if (append_ok) begin
			tail_q <= append_start + AW'(size_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			out_data_q <= {6'd0, res_status_q, res_addr_q};
		end
	end

	// checks
	`FFA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(ENTRIES))
	`FFA_ASSERT_NOW(a_rd_stage_in_table, v_s1, {1'b0, idx_s1} < (IW + 1)'(count_q))
	`FFA_ASSERT_NOW(a_write_only_scanning, mem_we, state_q == ST_SCAN)
	`FFA_ASSERT_NEXT(a_idle_keeps_table, state_q == ST_IDLE,
		count_q == $past(count_q) && used_q == $past(used_q))

endmodule

`default_nettype wire

[dv/tb_first_fit_block_allocator.sv]
// Self-checking testbench for the first-fit block allocator: directed table, random traffic.
module tb_first_fit_block_allocator;

	localparam int ENTRIES     = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int END_WAIT    = 80;

	// byte addresses of the two registers
	localparam logic [ffa_pkg::APB_ADDR_W-1:0] ADDR_REGION_BASE =
		{ffa_pkg::REG_REGION_BASE, 2'b00};
	localparam logic [ffa_pkg::APB_ADDR_W-1:0] ADDR_POOL_BYTES  =
		{ffa_pkg::REG_POOL_BYTES, 2'b00};

	// pool start used by the directed part, chosen so appends wrap past 0xFFFF
	localparam logic [15:0] DIR_BASE = 16'hFFF8;

	typedef struct packed {
		logic [15:0]      granted;
		ffa_pkg::status_t status;
	} alloc_result_t;

	typedef struct packed {
		logic             mode;
		logic [15:0]      size;
		logic [15:0]      addr;
		logic             typed;
		logic [15:0]      exp_granted;
		ffa_pkg::status_t exp_status;
	} directed_row_t;

	localparam int DIR_ROWS = 16;
	localparam directed_row_t DIRECTED [DIR_ROWS] = '{
		// refused before anything exists
		'{ffa_pkg::MODE_ALLOC, 16'd4097, 16'h0000, 1'b1, 16'h0000, ffa_pkg::ST_NOSPACE},
		'{ffa_pkg::MODE_ALLOC, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, ffa_pkg::ST_NOSPACE},
		// zero-size append at the pool start, then a second record on the same start
		'{ffa_pkg::MODE_ALLOC, 16'd0,    16'h0000, 1'b1, DIR_BASE, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_ALLOC, 16'd100,  16'h0000, 1'b1, DIR_BASE, ffa_pkg::ST_OK},
		// append wraps around the address space
		'{ffa_pkg::MODE_ALLOC, 16'd16,   16'h0000, 1'b1, 16'h005C, ffa_pkg::ST_OK},
		// shared start freed at once, then double free and unknown address
		'{ffa_pkg::MODE_FREE,  16'd0,    DIR_BASE, 1'b1, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_FREE,  16'hFFFF, DIR_BASE, 1'b1, 16'h0000, ffa_pkg::ST_NOTFOUND},
		'{ffa_pkg::MODE_FREE,  16'd0,    16'hFFFF, 1'b1, 16'h0000, ffa_pkg::ST_NOTFOUND},
		// oversized reuse, zero-size reuse, fill the pool exactly
		'{ffa_pkg::MODE_ALLOC, 16'd40,   16'h0000, 1'b0, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_ALLOC, 16'd0,    16'h0000, 1'b0, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_ALLOC, 16'd3980, 16'hFFFF, 1'b0, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_ALLOC, 16'd0,    16'h0000, 1'b0, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_ALLOC, 16'd1,    16'h0000, 1'b0, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_FREE,  16'd0,    16'h006C, 1'b0, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_FREE,  16'd0,    16'h005C, 1'b0, 16'h0000, ffa_pkg::ST_OK},
		'{ffa_pkg::MODE_ALLOC, 16'd20,   16'hFFFF, 1'b0, 16'h0000, ffa_pkg::ST_OK}
	};

	logic clk;
	logic arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	logic                           psel    = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite  = 1'b0;
	logic [ffa_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [31:0]                    pwdata  = '0;
	logic [31:0]                    prdata;
	logic                           pready;

	first_fit_block_allocator #(
		.ENTRIES  (ENTRIES),
		.ADDR_BITS(16)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted allocator state
	logic [15:0] rec_start [ENTRIES];
	logic [15:0] rec_len   [ENTRIES];
	logic        rec_busy  [ENTRIES];
	int          rec_count;
	logic [16:0] used_bytes;
	logic [15:0] cfg_base;
	logic [15:0] cfg_pool;

	alloc_result_t pending_results [$];
	alloc_result_t front_result;

	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          rdy_cycle      = 0;
	int          burst_left     = 0;
	int          status_seen [4];
	logic [16:0] peak_used      = '0;
	logic [15:0] last_granted   = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// saturating add into the used-byte count
	function automatic logic [16:0] used_plus(logic [16:0] u, logic [15:0] n);
		logic [17:0] sum;
		sum = u + n;
		return (sum > {1'b0, ffa_pkg::USED_MAX}) ? ffa_pkg::USED_MAX : sum[16:0];
	endfunction

	// first-fit allocate / free against the predicted table
	function automatic alloc_result_t predict_request(logic mode, logic [15:0] size,
			logic [15:0] addr);
		alloc_result_t res;
		logic          hit;
		logic [16:0]   unused;
		logic [15:0]   start;
		res.granted = '0;
		res.status  = ffa_pkg::ST_OK;
		hit = 1'b0;
		if (mode == ffa_pkg::MODE_ALLOC) begin
			unused = (used_bytes >= {1'b0, cfg_pool}) ? 17'd0 : {1'b0, cfg_pool} - used_bytes;
			if ({1'b0, size} > unused) begin
				res.status = ffa_pkg::ST_NOSPACE;
			end else begin
				for (int i = 0; i < rec_count && !hit; i++) begin
					if (!rec_busy[i] && rec_len[i] >= size) begin
						rec_busy[i] = 1'b1;
						used_bytes  = used_plus(used_bytes, rec_len[i]);
						res.granted = rec_start[i];
						hit = 1'b1;
					end
				end
				if (!hit) begin
					if (rec_count >= ENTRIES) begin
						res.status = ffa_pkg::ST_FULL;
					end else begin
						if (rec_count > 0)
							start = rec_start[rec_count-1] + rec_len[rec_count-1];
						else
							start = cfg_base;
						rec_start[rec_count] = start;
						rec_len[rec_count]   = size;
						rec_busy[rec_count]  = 1'b1;
						rec_count++;
						used_bytes  = used_plus(used_bytes, size);
						res.granted = start;
					end
				end
			end
		end else begin
			for (int i = 0; i < rec_count; i++) begin
				if (rec_busy[i] && rec_start[i] == addr) begin
					rec_busy[i] = 1'b0;
					used_bytes = ({1'b0, rec_len[i]} >= used_bytes) ? 17'd0 :
						used_bytes - rec_len[i];
					hit = 1'b1;
				end
			end
			if (!hit)
				res.status = ffa_pkg::ST_NOTFOUND;
		end
		return res;
	endfunction

	// drive one request word, wait for the handshake, then keep bursting or take a gap
	task automatic send_request(logic mode, logic [15:0] size, logic [15:0] addr,
			logic typed, alloc_result_t typed_res);
		alloc_result_t pred;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {addr, size};
		do @(posedge clk); while (!s_tready);
		pred = predict_request(mode, size, addr);
		pending_results.push_back(typed ? typed_res : pred);
		status_seen[pred.status]++;
		if (used_bytes > peak_used)
			peak_used = used_bytes;
		if (mode == ffa_pkg::MODE_ALLOC && pred.status == ffa_pkg::ST_OK)
			last_granted = pred.granted;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(6);
		end
	endtask

	// hold the sender off until every pending result is out
	task automatic drain_pending();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_register(logic [ffa_pkg::APB_ADDR_W-1:0] a, logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (a == ADDR_REGION_BASE)
			cfg_base = value;
		else if (a == ADDR_POOL_BYTES)
			cfg_pool = value;
	endtask

	// random requests: slightly more allocates than frees; frees mostly of known records, sizes mostly small or reused
	task automatic random_requests(int count);
		logic        mode;
		logic [15:0] size;
		logic [15:0] addr;
		int          pick;
		for (int n = 0; n < count; n++) begin
			mode = ($urandom_range(99) < 55) ? ffa_pkg::MODE_ALLOC : ffa_pkg::MODE_FREE;
			size = 16'($urandom);
			addr = 16'($urandom);
			pick = $urandom_range(9);
			if (mode == ffa_pkg::MODE_ALLOC) begin
				if (pick < 2)
					size = '0;
				else if (pick < 5 && rec_count > 0)
					size = rec_len[$urandom_range(rec_count-1)];
				else if (pick < 8)
					size = 16'($urandom_range(512, 1));
				else if (pick < 9)
					size = 16'($urandom_range(8192));
			end else begin
				if (pick < 6 && rec_count > 0)
					addr = rec_start[$urandom_range(rec_count-1)];
				else if (pick < 8)
					addr = last_granted;
			end
			send_request(mode, size, addr, 1'b0, '0);
		end
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %h", m_tdata));
			end else begin
				front_result = pending_results.pop_front();
				if (m_tdata[15:0] !== front_result.granted)
					report_mismatch($sformatf("granted_address %h, predicted %h",
						m_tdata[15:0], front_result.granted));
				if (m_tdata[17:16] !== front_result.status)
					report_mismatch($sformatf("status %0d, predicted %s",
						m_tdata[17:16], front_result.status.name()));
			end
		end
		rdy_cycle++;
		case ((rdy_cycle >> 8) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(1) == 1);
			2: m_tready <= ($urandom_range(3) == 0);
			default: m_tready <= (rdy_cycle % 7 == 0);
		endcase
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_results.size());
		$display("first_fit_block_allocator verification failed");
		$finish;
	end

	initial begin
		rec_count  = 0;
		used_bytes = '0;
		cfg_base   = ffa_pkg::REGION_BASE_RST;
		cfg_pool   = ffa_pkg::POOL_BYTES_RST;
		for (int i = 0; i < ENTRIES; i++) begin
			rec_start[i] = '0;
			rec_len[i]   = '0;
			rec_busy[i]  = 1'b0;
		end
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// region_base only matters before the first append
		write_register(ADDR_REGION_BASE, DIR_BASE);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++)
			send_request(DIRECTED[r].mode, DIRECTED[r].size, DIRECTED[r].addr,
				DIRECTED[r].typed, '{DIRECTED[r].exp_granted, DIRECTED[r].exp_status});

		// largest pool: table fills up
		drain_pending();
		write_register(ADDR_POOL_BYTES, 16'hFFFF);
		write_register(ADDR_REGION_BASE, 16'h0000);
		random_requests(170);

		// empty pool: only zero-size allocates pass
		drain_pending();
		write_register(ADDR_POOL_BYTES, 16'h0000);
		random_requests(120);

		// pool lowered below what is in use
		drain_pending();
		write_register(ADDR_POOL_BYTES, 16'd300);
		write_register(ADDR_REGION_BASE, 16'hFFFF);
		random_requests(150);

		// back to the largest pool
		drain_pending();
		write_register(ADDR_POOL_BYTES, 16'hFFFF);
		random_requests(210);

		drain_pending();
		repeat (END_WAIT) @(posedge clk);

		$display("requests: %0d ok, %0d out_of_space, %0d table_full, %0d not_found",
			status_seen[ffa_pkg::ST_OK], status_seen[ffa_pkg::ST_NOSPACE],
			status_seen[ffa_pkg::ST_FULL], status_seen[ffa_pkg::ST_NOTFOUND]);
		$display("records at end %0d of %0d, peak used bytes %0d, mismatches %0d",
			rec_count, ENTRIES, peak_used, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("first_fit_block_allocator verification clean");
		end else begin
			$display("first_fit_block_allocator verification failed");
		end
		$finish;
	end

endmodule
